// File: hw/rtl/cascaded_bridge_sine_modulator_defines.svh
// assertion macros for the cascaded bridge sine modulator
// used by the top level only, no other dependencies
`ifndef CASCADED_BRIDGE_SINE_MODULATOR_DEFINES_SVH
`define CASCADED_BRIDGE_SINE_MODULATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define CBSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled beat keeps its valid and payload
`define CBSM_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld) && !(rdy) |=> (vld) && $stable(sig)) else $error(msg);

`endif

// File: hw/rtl/cbsm_pkg.sv
// shared types, constants and the sine table function for the modulator
// no dependencies
`default_nettype none
package cbsm_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned TableBits = $clog2(TableSize);

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegBsel = 3'd1;
  localparam logic [2:0] RegMidx = 3'd2;
  localparam logic [2:0] RegStep = 3'd3;
  localparam logic [2:0] RegPeriod = 3'd4;
  localparam logic [2:0] RegPticks = 3'd5;

  localparam logic [1:0] ModePsc = 2'd1;
  localparam logic [1:0] ModeAlt = 2'd2;
  localparam logic [1:0] BselOne = 2'd1;
  localparam logic [1:0] BselTwo = 2'd2;

  // ceil(0.2 * 2^31) and ceil(0.6 * 2^31)
  localparam logic signed [31:0] RefT1 = 32'sd429496730;
  localparam logic signed [31:0] RefT2 = 32'sd1288490189;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  bsel;
    logic [15:0] midx;
    logic [23:0] step;
    logic [15:0] period;
    logic [15:0] pticks;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] cmp_b1_a;
    logic [15:0] cmp_b1_b;
    logic [15:0] cmp_b2_a;
    logic [15:0] cmp_b2_b;
    logic        high_sides_on;
    logic [2:0]  level;
    logic        precharge_done;
  } result_t;

  // quarter sine in Q15, fixed-point taylor series, evaluated at elaboration
  function automatic logic [15:0] quarter_sine(longint unsigned u);
    longint unsigned x, x2, term, sum, r;
    x = (64'd1686629713 * u) >> TableBits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - term;
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  function automatic logic [15:0] sine_entry(longint unsigned i);
    longint unsigned u, n;
    logic neg;
    logic [15:0] v;
    n = longint'(TableSize);
    u = 4 * i;
    neg = 1'b0;
    if (u >= 2 * n) begin
      neg = 1'b1;
      u = u - 2 * n;
    end
    if (u > n) u = 2 * n - u;
    v = quarter_sine(u);
    return neg ? 16'(17'h10000 - {1'b0, v}) : v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cbsm_if.sv
// valid/ready channel carrying one payload beat
// depends on nothing
`default_nettype none
interface cbsm_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cascaded_bridge_sine_modulator.sv
// five-level cascaded h-bridge sine modulator, top level
// depends on cbsm_pkg, cbsm_if, cbsm_regs, cbsm_core and the defines header
//
// usage: one beat on the tick channel per carrier period, payload
// precharge_armed. each tick beat yields exactly one result beat with the
// four leg compares, high_sides_on, level and precharge_done.
// each tick runs the sequencer through the rom read, then steps the single shared
// multiplier through the reference product, three period scalings and
// the two phase-shifted duty products; a new tick is taken only once the
// sequencer is back in idle.
// the tick channel is ready whenever the sequencer is idle; a result beat
// that waits holds the sequencer in its last step, so a stalled receiver
// holds off further ticks and nothing is dropped.
// reset: phase, precharge count and flags clear, high sides enabled, the
// registers take their documented values. no clearing pass is needed.
// registers are written through the apb port at byte address 4*index;
// write them only while the block is idle, which the block does not enforce.
//
`include "cascaded_bridge_sine_modulator_defines.svh"
`default_nettype none
module cascaded_bridge_sine_modulator
  import cbsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  cbsm_if.sink             tick_in,
  cbsm_if.source           res_out
);
  cfg_t cfg;
  result_t res;

  cbsm_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  cbsm_core u_core (
    .clk_i, .rst_ni,
    .cfg_i(cfg),
    .in_valid_i(tick_in.valid),
    .in_armed_i(tick_in.data),
    .in_ready_o(tick_in.ready),
    .res_valid_o(res_out.valid),
    .res_ready_i(res_out.ready),
    .res_o(res)
  );
  assign res_out.data = res;

  `CBSM_ASSERT(a_single_tick, clk_i, rst_ni,
    (tick_in.valid && tick_in.ready |=> !tick_in.ready), "tick taken while busy")
  `CBSM_ASSERT_HOLD(a_result_holds, clk_i, rst_ni, res_out.valid, res_out.ready,
    res_out.data, "result changed under stall")
  `CBSM_ASSERT(a_precharge_hs_off, clk_i, rst_ni,
    (res_out.valid && res.valid && !res.precharge_done |-> !res.high_sides_on),
    "high sides on during precharge")
endmodule
`default_nettype wire

// File: hw/rtl/cbsm_regs.sv
// apb-style configuration register file
// depends on cbsm_pkg
`default_nettype none
module cbsm_regs
  import cbsm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);
  cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        RegMode:   cfg_d.mode = pwdata[1:0];
        RegBsel:   cfg_d.bsel = pwdata[1:0];
        RegMidx:   cfg_d.midx = pwdata[15:0];
        RegStep:   cfg_d.step = pwdata[23:0];
        RegPeriod: cfg_d.period = pwdata[15:0];
        RegPticks: cfg_d.pticks = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegMode:   prdata = {30'd0, cfg_q.mode};
      RegBsel:   prdata = {30'd0, cfg_q.bsel};
      RegMidx:   prdata = {16'd0, cfg_q.midx};
      RegStep:   prdata = {8'd0, cfg_q.step};
      RegPeriod: prdata = {16'd0, cfg_q.period};
      RegPticks: prdata = {16'd0, cfg_q.pticks};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 2'd0, bsel: 2'd0, midx: 16'd52429, step: 24'd167772,
                 period: 16'd6399, pticks: 16'd30};
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/cbsm_core.sv
// tick sequencer around one shared 33x18 multiplier
// depends on cbsm_pkg
`default_nettype none
module cbsm_core
  import cbsm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic in_valid_i,
  input  wire logic in_armed_i,
  output logic      in_ready_o,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output result_t   res_o
);
  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StRom   = 8'b0000_0010,
    StRef   = 8'b0000_0100,
    StHi    = 8'b0000_1000,
    StLo    = 8'b0001_0000,
    StNeu   = 8'b0010_0000,
    StDa    = 8'b0100_0000,
    StDb    = 8'b1000_0000
  } state_e;

  localparam int unsigned PhW = TableBits + 16;

  logic [15:0] rom [TableSize];
  for (genvar g = 0; g < TableSize; g++) begin : g_rom
    assign rom[g] = sine_entry(longint'(g));
  end

  state_e state_q, state_d;
  logic [PhW-1:0] phase_q;
  logic [15:0] pcount_q, pcount_d;
  logic pdone_q, pdone_d, hse_q, hse_d, alt_q, alt_d, armed_q;
  logic [2:0] lvl_q, lvl_d, altprev_q, altprev_d;
  logic [15:0] sample_q;
  logic signed [31:0] ref_q;
  logic [15:0] hi_q, lo_q, neu_q, da_q;
  logic out_full_q, out_full_d;
  result_t res_q, res_d;
  logic fire;
  logic run;

  // shared multiplier: 33-bit operand by 18-bit operand
  logic signed [32:0] ma;
  logic signed [17:0] mb;
  logic signed [50:0] mp;
  assign mp = ma * mb;

  logic signed [32:0] na, nb;
  assign na = 33'sd2147483648 + 33'(ref_q);
  assign nb = 33'sd2147483648 - 33'(ref_q);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      StRef: begin ma = 33'(signed'(sample_q)); mb = signed'({2'b0, cfg_i.midx}); end
      // 19/20 ~ 62259/65536 with a correction below, 1/100 via 41944/2^22
      StHi:  begin ma = signed'({17'd0, cfg_i.period}); mb = 18'sd62259; end
      StLo:  begin ma = signed'({17'd0, cfg_i.period}); mb = 18'sd41944; end
      StNeu: begin ma = signed'({17'd0, cfg_i.period}); mb = 18'sd52429; end
      StDa:  begin ma = na; mb = signed'({2'b0, cfg_i.period}); end
      StDb:  begin ma = nb; mb = signed'({2'b0, cfg_i.period}); end
      default: ;
    endcase
  end

  // exact-floor corrections for the reciprocal products
  logic [20:0] p19;
  logic [16:0] q19, q100, q20;
  always_comb begin
    p19 = 21'(cfg_i.period) * 21'd19;
    q19 = 17'(mp[50:16]);
    if (21'({q19, 4'b0}) + 21'({q19, 2'b0}) > p19 && q19 != 0) q19 = q19 - 1'b1;
    if (21'({q19, 4'b0}) + 21'({q19, 2'b0}) + 21'd20 <= p19) q19 = q19 + 1'b1;
    q100 = 17'(mp[50:22]);
    if (24'(q100) * 24'd100 > 24'(cfg_i.period) && q100 != 0) q100 = q100 - 1'b1;
    if (24'(q100) * 24'd100 + 24'd100 <= 24'(cfg_i.period)) q100 = q100 + 1'b1;
    q20 = 17'(mp[50:20]);
    if (24'(q20) * 24'd20 > 24'(cfg_i.period) && q20 != 0) q20 = q20 - 1'b1;
    if (24'(q20) * 24'd20 + 24'd20 <= 24'(cfg_i.period)) q20 = q20 + 1'b1;
  end

  logic [15:0] pscv;
  always_comb begin
    pscv = 16'(mp[47:32]);
    if (pscv < neu_q) pscv = neu_q;
    if (pscv > hi_q) pscv = hi_q;
  end

  function automatic logic [2:0] quant(logic signed [31:0] r);
    if (r >= RefT2) return 3'sd2;
    if (r >= RefT1) return 3'sd1;
    if (r <= -RefT2) return -3'sd2;
    if (r <= -RefT1) return -3'sd1;
    return 3'd0;
  endfunction

  function automatic logic [31:0] legs(logic signed [2:0] b, logic [15:0] h, logic [15:0] l);
    if (b > 0) return {h, l};
    if (b < 0) return {l, h};
    return {l, l};
  endfunction

  logic [2:0] lv;
  logic alt_n;
  logic signed [2:0] b1, b2;
  always_comb begin
    lv = quant(ref_q);
    alt_n = alt_q;
    if (cfg_i.mode == ModeAlt && lv != altprev_q &&
        (lv == 3'sd1 || lv == -3'sd1)) alt_n = ~alt_q;
    if ($signed(lv) == 3'sd2) begin b1 = 3'sd1; b2 = 3'sd1; end
    else if ($signed(lv) == -3'sd2) begin b1 = -3'sd1; b2 = -3'sd1; end
    else if (lv == 3'd0) begin b1 = 3'sd0; b2 = 3'sd0; end
    else if (cfg_i.mode == ModeAlt && alt_n) begin b1 = 3'sd0; b2 = $signed(lv); end
    else begin b1 = $signed(lv); b2 = 3'sd0; end
    if (cfg_i.bsel == BselOne) b2 = 3'sd0;
    else if (cfg_i.bsel == BselTwo) b1 = 3'sd0;
  end

  logic [PhW:0] ph_sum;
  assign ph_sum = {1'b0, phase_q} + (PhW+1)'(cfg_i.step);
  logic [15:0] pc_inc;
  assign pc_inc = pcount_q + 16'd1;

  // last step waits while the previous result beat is still held
  assign fire = (state_q == StDb) && (!out_full_q || res_ready_i);
  assign in_ready_o = (state_q == StIdle);
  assign res_valid_o = out_full_q;
  assign res_o = res_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i && in_ready_o) state_d = StRom;
      StRom:  state_d = StRef;
      StRef:  state_d = StHi;
      StHi:   state_d = StLo;
      StLo:   state_d = StNeu;
      StNeu:  state_d = StDa;
      StDa:   state_d = StDb;
      StDb:   if (fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_full_d = out_full_q;
    if (out_full_q && res_ready_i) out_full_d = 1'b0;
    if (fire) out_full_d = 1'b1;
  end

  // precharge bookkeeping and the result of one tick
  always_comb begin
    pcount_d = pcount_q;
    pdone_d = pdone_q;
    hse_d = hse_q;
    lvl_d = lvl_q;
    alt_d = alt_q;
    altprev_d = altprev_q;
    res_d = '0;
    run = 1'b1;
    if (!armed_q) begin
      pcount_d = '0;
      pdone_d = 1'b0;
      run = 1'b0;
    end else begin
      res_d.valid = 1'b1;
      if (!pdone_q) begin
        pcount_d = pc_inc;
        hse_d = 1'b0;
        if (pc_inc < cfg_i.pticks) run = 1'b0;
        else begin
          hse_d = 1'b1;
          pdone_d = 1'b1;
        end
      end
    end
    if (run) begin
      lvl_d = lv;
      if (cfg_i.mode == ModePsc) begin
        res_d.cmp_b1_a = da_q;
        res_d.cmp_b1_b = pscv;
        res_d.cmp_b2_a = da_q;
        res_d.cmp_b2_b = pscv;
        if (cfg_i.bsel == BselOne) begin
          res_d.cmp_b2_a = lo_q;
          res_d.cmp_b2_b = lo_q;
        end else if (cfg_i.bsel == BselTwo) begin
          res_d.cmp_b1_a = lo_q;
          res_d.cmp_b1_b = lo_q;
        end
      end else begin
        if (cfg_i.mode == ModeAlt) begin
          alt_d = alt_n;
          altprev_d = lv;
        end
        {res_d.cmp_b1_a, res_d.cmp_b1_b} = legs(b1, hi_q, lo_q);
        {res_d.cmp_b2_a, res_d.cmp_b2_b} = legs(b2, hi_q, lo_q);
      end
    end
    res_d.high_sides_on = hse_d;
    res_d.level = lvl_d;
    res_d.precharge_done = pdone_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= '0;
      pcount_q <= '0;
      pdone_q <= 1'b0;
      hse_q <= 1'b1;
      alt_q <= 1'b0;
      lvl_q <= '0;
      altprev_q <= '0;
      out_full_q <= 1'b0;
      armed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_full_q <= out_full_d;
      if (in_valid_i && in_ready_o) begin
        armed_q <= in_armed_i;
        phase_q <= ph_sum[PhW-1:0];
      end
      if (fire) begin
        pcount_q <= pcount_d;
        pdone_q <= pdone_d;
        hse_q <= hse_d;
        lvl_q <= lvl_d;
        alt_q <= alt_d;
        altprev_q <= altprev_d;
      end
    end
  end

  // payload registers of the datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StRom: sample_q <= rom[phase_q[PhW-1:16]];
      StRef: ref_q <= 32'(mp);
      StHi:  hi_q <= q19[15:0];
      StLo:  lo_q <= q100[15:0];
      StNeu: neu_q <= q20[15:0];
      StDa:  da_q <= pscv;
      default: ;
    endcase
    if (fire) res_q <= res_d;
  end
endmodule
`default_nettype wire

// File: verif/tb_cascaded_bridge_sine_modulator.sv
// testbench for the cascaded bridge sine modulator: ticks in, compare beats checked
// depends on cbsm_pkg, cbsm_if and the top level; it predicts each beat on its own
`timescale 1ns / 100ps
module tb_cascaded_bridge_sine_modulator;
  import cbsm_pkg::*;

  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbsm_if #(.payload_t(logic))    tick_if ();
  cbsm_if #(.payload_t(result_t)) res_if ();

  cascaded_bridge_sine_modulator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick_in (tick_if.sink),
    .res_out (res_if.source)
  );

  // predictor state and register copy
  logic [15:0] sine_tbl [256];
  logic [23:0] phase_acc;
  logic [15:0] pre_count;
  logic        pre_done;
  logic        hs_enable;
  logic [2:0]  last_lvl;
  logic [2:0]  alt_prev;
  logic        alt_second;
  cfg_t        cfg;

  logic    tick_queue [$];
  result_t beat_queue [$];
  int      sender_idle_pct;
  int      recv_idle_pct;
  logic    hold_ticks;
  int      fail_count;
  int      cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] quarter_q15(longint unsigned u);
    longint unsigned x, x2, term, sum, r;
    x = 64'd1686629713 * u / 64'd256;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

  function automatic int to_level(longint refv);
    if (refv >= 64'sd1288490189) return 2;
    if (refv >= 64'sd429496730) return 1;
    if (refv <= -64'sd1288490189) return -2;
    if (refv <= -64'sd429496730) return -1;
    return 0;
  endfunction

  function automatic logic [15:0] duty_cmp(longint unsigned numer, longint unsigned p);
    longint unsigned c, lo, hi;
    c = (numer * p) >> 32;
    lo = p / 20;
    hi = (p * 19) / 20;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return c[15:0];
  endfunction

  // legs of one bridge for a bridge level of -1, 0 or +1
  function automatic logic [31:0] bridge_legs(int b, logic [15:0] hi, logic [15:0] lo);
    if (b > 0) return {hi, lo};
    if (b < 0) return {lo, hi};
    return {lo, lo};
  endfunction

  function automatic result_t modulated_beat(logic armed);
    result_t r;
    logic [15:0] raw;
    longint refv, p;
    int lvl, b1, b2;
    logic [15:0] hi, lo, neu, da, db;
    logic [31:0] legs1, legs2;
    r = '0;
    phase_acc = phase_acc + cfg.step;
    raw = sine_tbl[phase_acc[23:16]];
    refv = longint'($signed(raw)) * longint'({1'b0, cfg.midx});
    if (!armed) begin
      pre_count = '0;
      pre_done = 1'b0;
    end else begin
      logic run;
      run = 1'b1;
      if (!pre_done) begin
        hs_enable = 1'b0;
        r.valid = 1'b1;
        pre_count = pre_count + 16'd1;
        if (pre_count < cfg.pticks) run = 1'b0;
        else begin
          hs_enable = 1'b1;
          pre_done = 1'b1;
        end
      end
      if (run) begin
        r.valid = 1'b1;
        p = longint'({1'b0, cfg.period});
        lvl = to_level(refv);
        last_lvl = 3'(lvl);
        hi = 16'((p * 19) / 20);
        lo = 16'(p / 100);
        if (cfg.mode == ModePsc) begin
          da = duty_cmp(64'd2147483648 + refv, p);
          db = duty_cmp(64'd2147483648 - refv, p);
          neu = lo;
          legs1 = {da, db};
          legs2 = {da, db};
          if (cfg.bsel == BselOne) legs2 = {neu, neu};
          else if (cfg.bsel == BselTwo) legs1 = {neu, neu};
        end else begin
          if (cfg.mode == ModeAlt) begin
            if (3'(lvl) != alt_prev && (lvl == 1 || lvl == -1)) alt_second = ~alt_second;
            alt_prev = 3'(lvl);
          end
          if (lvl >= 2) begin
            b1 = 1; b2 = 1;
          end else if (lvl <= -2) begin
            b1 = -1; b2 = -1;
          end else if (lvl == 0) begin
            b1 = 0; b2 = 0;
          end else if (cfg.mode == ModeAlt && alt_second) begin
            b1 = 0; b2 = lvl;
          end else begin
            b1 = lvl; b2 = 0;
          end
          if (cfg.bsel == BselOne) b2 = 0;
          else if (cfg.bsel == BselTwo) b1 = 0;
          legs1 = bridge_legs(b1, hi, lo);
          legs2 = bridge_legs(b2, hi, lo);
        end
        {r.cmp_b1_a, r.cmp_b1_b} = legs1;
        {r.cmp_b2_a, r.cmp_b2_b} = legs2;
      end
    end
    r.high_sides_on = hs_enable;
    r.level = last_lvl;
    r.precharge_done = pre_done;
    return r;
  endfunction

  // tick driver: prediction happens at the accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      tick_if.data <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) beat_queue.push_back(modulated_beat(tick_if.data));
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_queue.size() > 0 && !hold_ticks &&
            $urandom_range(99, 0) >= sender_idle_pct) begin
          tick_if.valid <= 1'b1;
          tick_if.data <= tick_queue.pop_front();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (beat_queue.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %0h", $time, res_if.data);
          fail_count++;
        end else begin
          result_t e;
          e = beat_queue.pop_front();
          check_field("compares_valid", e.valid, res_if.data.valid);
          check_field("cmp_b1_a", e.cmp_b1_a, res_if.data.cmp_b1_a);
          check_field("cmp_b1_b", e.cmp_b1_b, res_if.data.cmp_b1_b);
          check_field("cmp_b2_a", e.cmp_b2_a, res_if.data.cmp_b2_a);
          check_field("cmp_b2_b", e.cmp_b2_b, res_if.data.cmp_b2_b);
          check_field("high_sides_on", e.high_sides_on, res_if.data.high_sides_on);
          check_field("level", e.level, res_if.data.level);
          check_field("precharge_done", e.precharge_done, res_if.data.precharge_done);
        end
      end
      res_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegMode:   cfg.mode = value[1:0];
      RegBsel:   cfg.bsel = value[1:0];
      RegMidx:   cfg.midx = value[15:0];
      RegStep:   cfg.step = value[23:0];
      RegPeriod: cfg.period = value[15:0];
      RegPticks: cfg.pticks = value[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (tick_queue.size() > 0 || tick_if.valid || beat_queue.size() > 0)
      @(posedge clk_i);
    // the block can still be busy after the last beat
    repeat (12) @(posedge clk_i);
  endtask

  task automatic load_config(cfg_t c);
    reg_write(RegMode, 32'(c.mode));
    reg_write(RegBsel, 32'(c.bsel));
    reg_write(RegMidx, 32'(c.midx));
    reg_write(RegStep, 32'(c.step));
    reg_write(RegPeriod, 32'(c.period));
    reg_write(RegPticks, 32'(c.pticks));
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.mode = 2'($urandom_range(3, 0));
    c.bsel = 2'($urandom_range(3, 0));
    case ($urandom_range(3, 0))
      0: c.midx = 16'd0;
      1: c.midx = 16'd62259;
      2: c.midx = 16'hffff;
      default: c.midx = 16'($urandom);
    endcase
    case ($urandom_range(4, 0))
      0: c.step = 24'hffffff;
      1: c.step = 24'($urandom_range(200000, 0));
      default: c.step = 24'($urandom);
    endcase
    case ($urandom_range(4, 0))
      0: c.period = 16'd0;
      1: c.period = 16'hffff;
      2: c.period = 16'($urandom_range(200, 1));
      default: c.period = 16'($urandom);
    endcase
    case ($urandom_range(9, 0))
      0: c.pticks = 16'd0;
      1: c.pticks = 16'hffff;
      default: c.pticks = 16'($urandom_range(40, 1));
    endcase
    return c;
  endfunction

  initial begin
    cfg_t c;
    for (int i = 0; i < 256; i++) begin
      int unsigned u;
      logic neg;
      logic [15:0] v;
      u = 4 * i;
      neg = 1'b0;
      if (u >= 512) begin
        neg = 1'b1;
        u = u - 512;
      end
      if (u > 256) u = 512 - u;
      v = quarter_q15(u);
      sine_tbl[i] = neg ? 16'(17'h10000 - {1'b0, v}) : v;
    end
    phase_acc = '0;
    pre_count = '0;
    pre_done = 1'b0;
    hs_enable = 1'b1;
    last_lvl = '0;
    alt_prev = '0;
    alt_second = 1'b0;
    cfg.mode = 2'd0;
    cfg.bsel = 2'd0;
    cfg.midx = 16'd52429;
    cfg.step = 24'd167772;
    cfg.period = 16'd6399;
    cfg.pticks = 16'd30;
    fail_count = 0;
    cycle_count = 0;
    hold_ticks = 1'b0;
    sender_idle_pct = 13;
    recv_idle_pct = 65;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, disarmed ticks, then armed ticks through a full precharge
    repeat (3) tick_queue.push_back(1'b0);
    repeat (34) tick_queue.push_back(1'b1);
    wait_drained();
    // short precharge, large step, full scale, psc and alt stair
    c = '{mode: ModePsc, bsel: 2'd0, midx: 16'hffff, step: 24'h0b0000,
          period: 16'hffff, pticks: 16'd2};
    load_config(c);
    tick_queue.push_back(1'b0);
    repeat (10) tick_queue.push_back(1'b1);
    wait_drained();
    c.mode = ModeAlt;
    c.period = 16'd1;
    c.step = 24'hffffff;
    load_config(c);
    tick_queue.push_back(1'b0);
    repeat (10) tick_queue.push_back(1'b1);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        sender_idle_pct = 65;
        recv_idle_pct = 13;
      end else if (ph == 8) begin
        sender_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_config(random_config());
      // mostly armed runs, broken by the odd disarm
      for (int k = 0; k < 150; k++)
        tick_queue.push_back($urandom_range(99, 0) >= 8);
      if (ph == 5) begin
        while (tick_queue.size() > 75) @(posedge clk_i);
        hold_ticks = 1'b1;
        while (tick_if.valid || beat_queue.size() > 0) @(posedge clk_i);
        hold_ticks = 1'b0;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cbsm_pkg.sv
hw/rtl/cbsm_if.sv
hw/rtl/cbsm_regs.sv
hw/rtl/cbsm_core.sv
hw/rtl/cascaded_bridge_sine_modulator.sv
verif/tb_cascaded_bridge_sine_modulator.sv
